// ===== hdl/hcr_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and the elaboration-time 1/sqrt(3) function for
// the hex picking pipeline. No dependencies.
package hcr_pkg;

    localparam int SIZE_W = 12;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 12'd144;
    localparam int CUBE_W = 17;

    // Signs of the two numerators, carried alongside the magnitudes.
    typedef struct packed {
        logic sign_x;
        logic sign_y;
    } hcr_sign_t;

    // round(2^frac_bits / sqrt(3)) via integer square root of 2^(2f+2)/3.
    // Elaboration only.
    function automatic longint unsigned inv_sqrt3(input int frac_bits);
        longint unsigned n;
        longint unsigned res;
        longint unsigned bit_v;
        n = (64'd1 << (2 * frac_bits + 2)) / 64'd3;
        res = 64'd0;
        bit_v = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (n >= res + bit_v)
            begin
                n = n - (res + bit_v);
                res = (res >> 1) + bit_v;
            end
            else
            begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return (res + 64'd1) >> 1;
    endfunction

endpackage

// ===== hdl/hcr_pixel_if.sv =====
`timescale 1ns / 1ps
// Input channel: one pixel position per word.
// Depends on nothing.
interface hcr_pixel_if #(
    parameter int PIXEL_BITS = 16
) ();
    logic                         valid;
    logic                         ready;
    logic signed [PIXEL_BITS-1:0] pixel_x;
    logic signed [PIXEL_BITS-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

// ===== hdl/hcr_cube_if.sv =====
`timescale 1ns / 1ps
// Output channel: one cube coordinate triple per word.
// Depends on hcr_pkg.
interface hcr_cube_if
    import hcr_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [CUBE_W-1:0] cube_x;
    logic signed [CUBE_W-1:0] cube_y;
    logic signed [CUBE_W-1:0] cube_z;

    modport source (output valid, output cube_x, output cube_y, output cube_z,
                    input ready);
    modport sink (input valid, input cube_x, input cube_y, input cube_z,
                  output ready);
endinterface

// ===== hdl/hcr_cfg_if.sv =====
`timescale 1ns / 1ps
// Configuration write channel carrying the hex size.
// Depends on hcr_pkg.
interface hcr_cfg_if
    import hcr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] hex_size;

    modport source (output valid, output hex_size, input ready);
    modport sink (input valid, input hex_size, output ready);
endinterface

// ===== hdl/pixel_to_hex_cube_round.sv =====
`timescale 1ns / 1ps
// Pointy-top hex picking: each word on pixel carries a signed pixel position;
// cube returns the cube coordinates of the hexagon holding it, one word per
// input word, in order. One word is accepted per clock when the output side
// keeps up. The pipeline is the divider, which retires one quotient bit per
// stage, plus two front stages (multiply by 1/sqrt(3), numerator and sign
// split) and five back stages (signed quotients, fz, its magnitude, rounding,
// rebuild into the output register). Stalls on cube fill pipeline bubbles
// first, so pixel keeps accepting while a result waits. hex_size is written
// on cfg (always ready, reset 144, 0 acts as 1) and must only change while no
// word is in flight. Results wrap to 17 bits.
// Depends on hcr_pkg, the three channel interfaces, hcr_front, hcr_divider,
// hcr_round.
module pixel_to_hex_cube_round
    import hcr_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int PIXEL_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    hcr_pixel_if.sink  pixel,
    hcr_cube_if.source cube,
    hcr_cfg_if.sink    cfg
);

    localparam int MW = PIXEL_BITS + FRAC_BITS;

    // normalized divisor: never zero
    logic [SIZE_W-1:0] size_reg;

    // front -> divider
    logic          fr_valid;
    logic          fr_ready;
    logic [MW-1:0] fr_mag_x;
    logic [MW-1:0] fr_mag_y;
    hcr_sign_t     fr_sign;

    // divider -> back end
    logic          dv_valid;
    logic          dv_ready;
    logic [MW-1:0] dv_quo_x;
    logic [MW-1:0] dv_quo_y;
    hcr_sign_t     dv_sign;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            size_reg <= (cfg.hex_size == '0) ? SIZE_W'(1) : cfg.hex_size;
        end
    end

    // x*2^F - y*R and 2*y*R, as sign and magnitude
    hcr_front #(
        .PIXEL_BITS (PIXEL_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixel.valid),
        .in_ready  (pixel.ready),
        .pixel_x   (pixel.pixel_x),
        .pixel_y   (pixel.pixel_y),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .mag_x     (fr_mag_x),
        .mag_y     (fr_mag_y),
        .sign      (fr_sign)
    );

    // truncating division of both magnitudes by hex_size
    hcr_divider #(
        .PIXEL_BITS (PIXEL_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .divisor   (size_reg),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .mag_x     (fr_mag_x),
        .mag_y     (fr_mag_y),
        .sign_in   (fr_sign),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .quo_x     (dv_quo_x),
        .quo_y     (dv_quo_y),
        .sign_out  (dv_sign)
    );

    // cube rounding; its last stage is the output register
    hcr_round #(
        .PIXEL_BITS (PIXEL_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv_valid),
        .in_ready  (dv_ready),
        .quo_x     (dv_quo_x),
        .quo_y     (dv_quo_y),
        .sign_in   (dv_sign),
        .out_valid (cube.valid),
        .out_ready (cube.ready),
        .cube_x    (cube.cube_x),
        .cube_y    (cube.cube_y),
        .cube_z    (cube.cube_z)
    );

    a_cube_sum_zero : assert property (@(posedge clk) disable iff (!rst_n)
        cube.valid |-> (CUBE_W'(cube.cube_x + cube.cube_y + cube.cube_z) == '0))
        else $error("cube coordinates do not sum to zero");

    a_ready_when_drained : assert property (@(posedge clk) disable iff (!rst_n)
        !cube.valid |-> pixel.ready)
        else $error("input blocked with empty output register");

    a_size_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
        size_reg != '0)
        else $error("divisor register is zero");

endmodule

// ===== hdl/hcr_front.sv =====
`timescale 1ns / 1ps
// Front end: multiply by 1/sqrt(3), form both numerators, split sign/magnitude.
// Two register stages. Depends on hcr_pkg.
module hcr_front
    import hcr_pkg::*;
#(
    parameter int PIXEL_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [PIXEL_BITS-1:0] pixel_x,
    input  logic signed [PIXEL_BITS-1:0] pixel_y,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [PIXEL_BITS+FRAC_BITS-1:0] mag_x,
    output logic [PIXEL_BITS+FRAC_BITS-1:0] mag_y,
    output hcr_sign_t                    sign
);

    localparam int MW = PIXEL_BITS + FRAC_BITS;
    localparam longint unsigned INV_FULL = inv_sqrt3(FRAC_BITS);
    localparam logic [FRAC_BITS-1:0] INV_SQRT3 = INV_FULL[FRAC_BITS-1:0];

    logic                         v0_reg;
    logic                         v1_reg;
    logic                         en0;
    logic                         en1;
    logic signed [PIXEL_BITS-1:0] px_reg;
    logic signed [MW:0]           prod_next;
    logic signed [MW:0]           prod_reg;
    logic signed [MW:0]           scaled;
    logic signed [MW:0]           num_x;
    logic signed [MW:0]           num_y;
    logic [MW-1:0]                mag_x_next;
    logic [MW-1:0]                mag_y_next;
    logic [MW-1:0]                mag_x_reg;
    logic [MW-1:0]                mag_y_reg;
    hcr_sign_t                    sign_reg;

    assign en1      = ~v1_reg | out_ready;
    assign en0      = ~v0_reg | en1;
    assign in_ready = en0;

    // y * R, R < 2^FRAC_BITS held unsigned
    assign prod_next = $signed((MW+1)'(pixel_y)) * $signed((MW+1)'({1'b0, INV_SQRT3}));

    assign scaled = {px_reg[PIXEL_BITS-1], px_reg, {FRAC_BITS{1'b0}}};
    assign num_x  = scaled - prod_reg;
    assign num_y  = prod_reg <<< 1;

    assign mag_x_next = num_x[MW] ? MW'(-num_x) : MW'(num_x);
    assign mag_y_next = num_y[MW] ? MW'(-num_y) : MW'(num_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            if (en0)
            begin
                v0_reg <= in_valid;
            end
            if (en1)
            begin
                v1_reg <= v0_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en0)
        begin
            px_reg   <= pixel_x;
            prod_reg <= prod_next;
        end
        if (en1)
        begin
            mag_x_reg       <= mag_x_next;
            mag_y_reg       <= mag_y_next;
            sign_reg.sign_x <= num_x[MW];
            sign_reg.sign_y <= num_y[MW];
        end
    end

    assign out_valid = v1_reg;
    assign mag_x     = mag_x_reg;
    assign mag_y     = mag_y_reg;
    assign sign      = sign_reg;

endmodule

// ===== hdl/hcr_divider.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider: two magnitudes by the hex size, one quotient
// bit per stage. Depends on hcr_pkg.
module hcr_divider
    import hcr_pkg::*;
#(
    parameter int PIXEL_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [SIZE_W-1:0]                   divisor,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [PIXEL_BITS+FRAC_BITS-1:0]     mag_x,
    input  logic [PIXEL_BITS+FRAC_BITS-1:0]     mag_y,
    input  hcr_sign_t                           sign_in,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [PIXEL_BITS+FRAC_BITS-1:0]     quo_x,
    output logic [PIXEL_BITS+FRAC_BITS-1:0]     quo_y,
    output hcr_sign_t                           sign_out
);

    localparam int MW = PIXEL_BITS + FRAC_BITS;

    logic [MW-1:0]     valid_reg;
    logic [MW:0]       en;
    logic [MW-1:0]     dvd_x_reg [MW];
    logic [MW-1:0]     dvd_y_reg [MW];
    logic [SIZE_W-1:0] rem_x_reg [MW];
    logic [SIZE_W-1:0] rem_y_reg [MW];
    hcr_sign_t         sign_reg  [MW];

    assign en[MW]   = out_ready;
    assign in_ready = en[0];

    for (genvar k = 0; k < MW; k++)
    begin : g_stage
        logic              v_in;
        logic [MW-1:0]     dvd_x_in;
        logic [MW-1:0]     dvd_y_in;
        logic [SIZE_W-1:0] rem_x_in;
        logic [SIZE_W-1:0] rem_y_in;
        hcr_sign_t         sign_stage_in;
        logic [SIZE_W:0]   t_x;
        logic [SIZE_W:0]   t_y;
        logic              ge_x;
        logic              ge_y;
        logic [SIZE_W-1:0] rem_x_next;
        logic [SIZE_W-1:0] rem_y_next;
        logic [MW-1:0]     dvd_x_next;
        logic [MW-1:0]     dvd_y_next;

        if (k == 0)
        begin : g_first
            assign v_in          = in_valid;
            assign dvd_x_in      = mag_x;
            assign dvd_y_in      = mag_y;
            assign rem_x_in      = '0;
            assign rem_y_in      = '0;
            assign sign_stage_in = sign_in;
        end
        else
        begin : g_rest
            assign v_in          = valid_reg[k-1];
            assign dvd_x_in      = dvd_x_reg[k-1];
            assign dvd_y_in      = dvd_y_reg[k-1];
            assign rem_x_in      = rem_x_reg[k-1];
            assign rem_y_in      = rem_y_reg[k-1];
            assign sign_stage_in = sign_reg[k-1];
        end

        assign en[k] = ~valid_reg[k] | en[k+1];

        // remainder stays below the divisor, so t < 2*divisor
        assign t_x  = {rem_x_in, dvd_x_in[MW-1]};
        assign t_y  = {rem_y_in, dvd_y_in[MW-1]};
        assign ge_x = t_x >= {1'b0, divisor};
        assign ge_y = t_y >= {1'b0, divisor};
        assign rem_x_next = ge_x ? SIZE_W'(t_x - {1'b0, divisor}) : SIZE_W'(t_x);
        assign rem_y_next = ge_y ? SIZE_W'(t_y - {1'b0, divisor}) : SIZE_W'(t_y);
        assign dvd_x_next = {dvd_x_in[MW-2:0], ge_x};
        assign dvd_y_next = {dvd_y_in[MW-2:0], ge_y};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en[k])
            begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                dvd_x_reg[k] <= dvd_x_next;
                dvd_y_reg[k] <= dvd_y_next;
                rem_x_reg[k] <= rem_x_next;
                rem_y_reg[k] <= rem_y_next;
                sign_reg[k]  <= sign_stage_in;
            end
        end
    end

    assign out_valid = valid_reg[MW-1];
    assign quo_x     = dvd_x_reg[MW-1];
    assign quo_y     = dvd_y_reg[MW-1];
    assign sign_out  = sign_reg[MW-1];

    a_rem_below_divisor : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (rem_x_reg[MW-1] < divisor) && (rem_y_reg[MW-1] < divisor))
        else $error("divider remainder not below divisor");

endmodule

// ===== hdl/hcr_round.sv =====
`timescale 1ns / 1ps
// Back end: derive fz, round all three half away from zero, rebuild the
// coordinate with the largest error. Five register stages. Depends on hcr_pkg.
module hcr_round
    import hcr_pkg::*;
#(
    parameter int PIXEL_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [PIXEL_BITS+FRAC_BITS-1:0]  quo_x,
    input  logic [PIXEL_BITS+FRAC_BITS-1:0]  quo_y,
    input  hcr_sign_t                        sign_in,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [CUBE_W-1:0]         cube_x,
    output logic signed [CUBE_W-1:0]         cube_y,
    output logic signed [CUBE_W-1:0]         cube_z
);

    localparam int MW = PIXEL_BITS + FRAC_BITS;
    localparam int NS = 5;

    logic [NS-1:0] valid_reg;
    logic [NS:0]   en;

    // stage 0: signed quotients
    logic signed [MW:0] fx_reg;
    logic signed [MW:0] fy_reg;
    logic [MW-1:0]      qx0_reg;
    logic [MW-1:0]      qy0_reg;
    hcr_sign_t          sg0_reg;
    logic signed [MW:0] fx_next;
    logic signed [MW:0] fy_next;

    // stage 1: fx + fy (fz is its negation)
    logic signed [MW+1:0] sum_reg;
    logic signed [MW+1:0] sum_next;
    logic [MW-1:0]        qx1_reg;
    logic [MW-1:0]        qy1_reg;
    hcr_sign_t            sg1_reg;

    // stage 2: |fz| and its sign
    logic [MW:0]   mz_reg;
    logic [MW:0]   mz_next;
    logic          sz_reg;
    logic [MW-1:0] qx2_reg;
    logic [MW-1:0] qy2_reg;
    hcr_sign_t     sg2_reg;

    // stage 3: rounded coordinates and errors
    logic [CUBE_W+FRAC_BITS-1:0] rnd_x;
    logic [CUBE_W+FRAC_BITS-1:0] rnd_y;
    logic [CUBE_W+FRAC_BITS-1:0] rnd_z;
    logic [CUBE_W-1:0]           rx_reg;
    logic [CUBE_W-1:0]           ry_reg;
    logic [CUBE_W-1:0]           rz_reg;
    logic [FRAC_BITS-1:0]        dx_reg;
    logic [FRAC_BITS-1:0]        dy_reg;
    logic [FRAC_BITS-1:0]        dz_reg;

    // stage 4: output register
    logic [CUBE_W-1:0] cx_next;
    logic [CUBE_W-1:0] cy_next;
    logic [CUBE_W-1:0] cz_next;
    logic [CUBE_W-1:0] cx_reg;
    logic [CUBE_W-1:0] cy_reg;
    logic [CUBE_W-1:0] cz_reg;

    // rounded magnitude (low CUBE_W bits, sign applied) and error magnitude
    function automatic logic [CUBE_W+FRAC_BITS-1:0] round_mag(
        input logic [MW:0] m,
        input logic        neg
    );
        logic [FRAC_BITS-1:0] frac;
        logic                 up;
        logic [MW:0]          q_full;
        logic [CUBE_W-1:0]    q_low;
        logic [FRAC_BITS-1:0] err;
        frac   = m[FRAC_BITS-1:0];
        up     = frac[FRAC_BITS-1];
        q_full = (m >> FRAC_BITS) + (MW+1)'(up);
        q_low  = CUBE_W'(q_full);
        if (neg)
        begin
            q_low = ~q_low + CUBE_W'(1);
        end
        err = up ? FRAC_BITS'(~frac + FRAC_BITS'(1)) : frac;
        return {q_low, err};
    endfunction

    assign en[NS]   = out_ready;
    assign in_ready = en[0];

    for (genvar k = 0; k < NS; k++)
    begin : g_en
        assign en[k] = ~valid_reg[k] | en[k+1];
    end

    assign fx_next  = sign_in.sign_x ? -$signed({1'b0, quo_x}) : $signed({1'b0, quo_x});
    assign fy_next  = sign_in.sign_y ? -$signed({1'b0, quo_y}) : $signed({1'b0, quo_y});
    assign sum_next = {fx_reg[MW], fx_reg} + {fy_reg[MW], fy_reg};
    assign mz_next  = sum_reg[MW+1] ? (MW+1)'(-sum_reg) : (MW+1)'(sum_reg);

    assign rnd_x = round_mag({1'b0, qx2_reg}, sg2_reg.sign_x);
    assign rnd_y = round_mag({1'b0, qy2_reg}, sg2_reg.sign_y);
    assign rnd_z = round_mag(mz_reg, sz_reg);

    // rebuild the worst coordinate; ties go to the later one
    always_comb
    begin
        cx_next = rx_reg;
        cy_next = ry_reg;
        cz_next = rz_reg;
        priority if ((dx_reg > dy_reg) && (dx_reg > dz_reg))
        begin
            cx_next = CUBE_W'(0) - ry_reg - rz_reg;
        end
        else if (dy_reg > dz_reg)
        begin
            cy_next = CUBE_W'(0) - rx_reg - rz_reg;
        end
        else
        begin
            cz_next = CUBE_W'(0) - rx_reg - ry_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            fx_reg  <= fx_next;
            fy_reg  <= fy_next;
            qx0_reg <= quo_x;
            qy0_reg <= quo_y;
            sg0_reg <= sign_in;
        end
        if (en[1])
        begin
            sum_reg <= sum_next;
            qx1_reg <= qx0_reg;
            qy1_reg <= qy0_reg;
            sg1_reg <= sg0_reg;
        end
        if (en[2])
        begin
            mz_reg  <= mz_next;
            // fz = -(fx + fy) is negative when the sum is positive
            sz_reg  <= ~sum_reg[MW+1] & (|sum_reg);
            qx2_reg <= qx1_reg;
            qy2_reg <= qy1_reg;
            sg2_reg <= sg1_reg;
        end
        if (en[3])
        begin
            rx_reg <= rnd_x[CUBE_W+FRAC_BITS-1:FRAC_BITS];
            ry_reg <= rnd_y[CUBE_W+FRAC_BITS-1:FRAC_BITS];
            rz_reg <= rnd_z[CUBE_W+FRAC_BITS-1:FRAC_BITS];
            dx_reg <= rnd_x[FRAC_BITS-1:0];
            dy_reg <= rnd_y[FRAC_BITS-1:0];
            dz_reg <= rnd_z[FRAC_BITS-1:0];
        end
        if (en[4])
        begin
            cx_reg <= cx_next;
            cy_reg <= cy_next;
            cz_reg <= cz_next;
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign cube_x    = $signed(cx_reg);
    assign cube_y    = $signed(cy_reg);
    assign cube_z    = $signed(cz_reg);

endmodule
